// File: sv/dmr_pkg.sv
// shared constants for the bit-parallel damerau search core
package dmr_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int ALPHABET_DEF  = 4;

    localparam int SYM_W      = 2;
    localparam int LEN_W      = 7;
    localparam int DIST_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PM0 = 3'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

endpackage

// File: sv/dmr_cfg.sv
// configuration registers and the derived pattern length, length mask and top bit
module dmr_cfg import dmr_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF,
    localparam int M_W      = $clog2(WORD_BITS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    output logic [M_W-1:0]                       o_len,
    output logic [WORD_BITS-1:0]                 o_mask,
    output logic [WORD_BITS-1:0]                 o_top,
    output logic [ALPHABET-1:0][WORD_BITS-1:0]   o_pm
);

    logic [LEN_W-1:0]                     r_len;
    logic [ALPHABET-1:0][WORD_BITS-1:0]   r_pm;
    logic [LEN_W-1:0]                     w_len_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid && i_cfg_index == CFG_IDX_LEN) begin
            r_len <= i_cfg_data[LEN_W-1:0];
        end
    end

    for (genvar a = 0; a < ALPHABET; a++) begin : g_pm
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pm[a] <= '0;
            end else if (i_cfg_valid && i_cfg_index == CFG_IDX_PM0 + CFG_IDX_W'(a)) begin
                r_pm[a] <= i_cfg_data[WORD_BITS-1:0];
            end
        end
    end

    // length saturated into 1..WORD_BITS
    always_comb begin
        if (r_len == '0) begin
            w_len_sat = LEN_W'(1);
        end else if (r_len > LEN_W'(WORD_BITS)) begin
            w_len_sat = LEN_W'(WORD_BITS);
        end else begin
            w_len_sat = r_len;
        end
    end

    for (genvar i = 0; i < WORD_BITS; i++) begin : g_mask
        assign o_mask[i] = LEN_W'(i) < w_len_sat;
        assign o_top[i]  = LEN_W'(i + 1) == w_len_sat;
    end

    assign o_len = w_len_sat[M_W-1:0];
    assign o_pm  = r_pm;

endmodule

// File: sv/dmr_step.sv
// one column update of the bit-parallel osa recurrence and the score
module dmr_step import dmr_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF,
    localparam int M_W      = $clog2(WORD_BITS + 1)
) (
    input  logic [SYM_W-1:0]                     i_sym,
    input  logic                                 i_new_text,
    input  logic [M_W-1:0]                       i_len,
    input  logic [WORD_BITS-1:0]                 i_mask,
    input  logic [WORD_BITS-1:0]                 i_top,
    input  logic [ALPHABET-1:0][WORD_BITS-1:0]   i_pm,
    input  logic [WORD_BITS-1:0]                 i_vp,
    input  logic [WORD_BITS-1:0]                 i_vn,
    input  logic [WORD_BITS-1:0]                 i_d0,
    input  logic [SYM_W-1:0]                     i_prev_sym,
    input  logic                                 i_prev_valid,
    input  logic [M_W-1:0]                       i_score,
    output logic [WORD_BITS-1:0]                 o_vp,
    output logic [WORD_BITS-1:0]                 o_vn,
    output logic [WORD_BITS-1:0]                 o_d0,
    output logic [M_W-1:0]                       o_score
);

    logic [WORD_BITS-1:0] w_vp, w_vn, w_d0p, w_pm, w_pm_prev;
    logic                 w_pvalid;
    logic [WORD_BITS-1:0] w_tr, w_sum, w_d0, w_hp, w_hn, w_x;
    logic [M_W-1:0]       w_sc, w_s1, w_s2;

    // symbols at or beyond the alphabet size match nothing
    function automatic logic [WORD_BITS-1:0] f_match(
        input logic [SYM_W-1:0]                   sym,
        input logic [ALPHABET-1:0][WORD_BITS-1:0] pm
    );
        logic [WORD_BITS-1:0] res;
        res = '0;
        for (int a = 0; a < ALPHABET; a++) begin
            if (sym == SYM_W'(a)) begin
                res = pm[a];
            end
        end
        return res;
    endfunction

    // restart values apply before this symbol when a new text begins
    always_comb begin
        if (i_new_text) begin
            w_vp     = i_mask;
            w_vn     = '0;
            w_d0p    = '0;
            w_pvalid = 1'b0;
            w_sc     = i_len;
        end else begin
            w_vp     = i_vp;
            w_vn     = i_vn;
            w_d0p    = i_d0;
            w_pvalid = i_prev_valid;
            w_sc     = i_score;
        end
    end

    assign w_pm      = f_match(i_sym, i_pm) & i_mask;
    assign w_pm_prev = w_pvalid ? (f_match(i_prev_sym, i_pm) & i_mask) : '0;

    assign w_tr  = ((~w_d0p & w_pm) << 1) & w_pm_prev & i_mask;
    assign w_sum = (w_pm & w_vp) + w_vp;
    assign w_d0  = (w_tr | (w_sum ^ w_vp) | w_pm | w_vn) & i_mask;
    assign w_hp  = (w_vn | ~(w_d0 | w_vp)) & i_mask;
    assign w_hn  = w_vp & w_d0 & i_mask;
    assign w_x   = (w_hp << 1) & i_mask;

    assign o_vp = ((w_hn << 1) | ~(w_d0 | w_x)) & i_mask;
    assign o_vn = w_x & w_d0;
    assign o_d0 = w_d0;

    // score saturates at zero and at the pattern length
    always_comb begin
        w_s1 = w_sc;
        if (|(w_hp & i_top) && w_sc < i_len) begin
            w_s1 = w_sc + M_W'(1);
        end
        w_s2 = w_s1;
        if (|(w_hn & i_top) && w_s1 != '0) begin
            w_s2 = w_s1 - M_W'(1);
        end
        o_score = (w_s2 > i_len) ? i_len : w_s2;
    end

endmodule

// File: sv/bit_parallel_damerau_search_core.sv
// top level of the bit-parallel damerau (osa) approximate search core
// accepted symbols enter the input register, their distances then go to the output register
// throughput: one symbol per cycle when not stalled, bounded by the word-wide carry add of the column update
// a waiting result stalls input only once the input register holds a symbol too
// reset (synchronous, active low): pattern length 1, match masks zero, search state as for
// a one-symbol pattern, both pipeline registers empty
module bit_parallel_damerau_search_core import dmr_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SYM_W-1:0]       i_text_symbol,
    input  logic                   i_new_text,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DIST_W-1:0]      o_distance,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int M_W = $clog2(WORD_BITS + 1);

    logic [M_W-1:0]                       w_len;
    logic [WORD_BITS-1:0]                 w_mask, w_top;
    logic [ALPHABET-1:0][WORD_BITS-1:0]   w_pm;

    logic                   r_in_valid;
    logic [SYM_W-1:0]       r_sym;
    logic                   r_new;
    logic                   r_out_valid;
    logic [DIST_W-1:0]      r_distance;

    logic [WORD_BITS-1:0]   r_vp, r_vn, r_d0;
    logic [SYM_W-1:0]       r_prev_sym;
    logic                   r_prev_valid;
    logic [M_W-1:0]         r_score;

    logic [WORD_BITS-1:0]   n_vp, n_vn, n_d0;
    logic [M_W-1:0]         n_score;

    logic                   w_out_free, w_advance, w_in_take;

    dmr_cfg #(
        .WORD_BITS (WORD_BITS),
        .ALPHABET  (ALPHABET)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_len       (w_len),
        .o_mask      (w_mask),
        .o_top       (w_top),
        .o_pm        (w_pm)
    );

    dmr_step #(
        .WORD_BITS (WORD_BITS),
        .ALPHABET  (ALPHABET)
    ) u_step (
        .i_sym        (r_sym),
        .i_new_text   (r_new),
        .i_len        (w_len),
        .i_mask       (w_mask),
        .i_top        (w_top),
        .i_pm         (w_pm),
        .i_vp         (r_vp),
        .i_vn         (r_vn),
        .i_d0         (r_d0),
        .i_prev_sym   (r_prev_sym),
        .i_prev_valid (r_prev_valid),
        .i_score      (r_score),
        .o_vp         (n_vp),
        .o_vn         (n_vn),
        .o_d0         (n_d0),
        .o_score      (n_score)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_sym <= i_text_symbol;
            r_new <= i_new_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_distance <= DIST_W'(n_score);
        end
    end

    // search state follows the column update once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp         <= WORD_BITS'(1'b1);
            r_vn         <= '0;
            r_d0         <= '0;
            r_prev_sym   <= '0;
            r_prev_valid <= 1'b0;
            r_score      <= M_W'(LEN_RESET);
        end else if (w_advance) begin
            r_vp         <= n_vp;
            r_vn         <= n_vn;
            r_d0         <= n_d0;
            r_prev_sym   <= r_sym;
            r_prev_valid <= 1'b1;
            r_score      <= n_score;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_valid && r_prev_valid))
        else $error("column update did not produce a result");

    a_take_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("accepted symbol lost from input register");

    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score <= M_W'(WORD_BITS))
        else $error("score beyond word size");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free pipeline");

endmodule

// File: verif/tb_bit_parallel_damerau_search_core.sv
// self-checking testbench for the bit-parallel damerau (osa) search core
`timescale 1ns / 1ps

module tb_bit_parallel_damerau_search_core;
    import dmr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_LEN      = WORD_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_PM0 + 3'd4;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             restart;
        int               gap;
    } t_text_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SYM_W-1:0]      i_text_symbol = '0;
    logic                  i_new_text = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DIST_W-1:0]     o_distance;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IDX_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bit_parallel_damerau_search_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_symbol (i_text_symbol),
        .i_new_text    (i_new_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_distance    (o_distance),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    t_text_item        symbol_q[$];
    logic [DIST_W-1:0] distance_q[$];
    int symbols_issued = 0;
    int distances_seen = 0;
    int phase_items = 0;
    int error_count = 0;
    int cycle_count = 0;
    int tx_gap_max = 6;
    int rx_busy_max = 6;
    int hold_req = 0;
    int hold_ack = 0;

    // mirror of the configuration registers
    logic [LEN_W-1:0]      cfg_len;
    logic [CFG_DATA_W-1:0] cfg_pm[ALPHABET_DEF];

    // mirror of the search state
    logic [MAX_LEN-1:0] st_vp, st_vn, st_diag;
    logic [SYM_W-1:0]   st_prev_sym;
    logic               st_prev_valid;
    logic [DIST_W-1:0]  st_score;

    // pattern used to build near-matching text
    logic [SYM_W-1:0] pattern_sym[MAX_LEN];
    int pattern_len_eff = 1;

    function automatic int active_len();
        int m;
        m = int'(cfg_len);
        if (m < 1) m = 1;
        if (m > MAX_LEN) m = MAX_LEN;
        return m;
    endfunction

    function automatic logic [MAX_LEN-1:0] len_mask(input int m);
        return (m >= MAX_LEN) ? '1 : ((64'd1 << m) - 64'd1);
    endfunction

    function automatic void restart_search();
        st_vp         = len_mask(active_len());
        st_vn         = '0;
        st_diag       = '0;
        st_prev_sym   = '0;
        st_prev_valid = 1'b0;
        st_score      = DIST_W'(active_len());
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(input logic [SYM_W-1:0] sym,
                                                           input logic restart_text);
        int m;
        logic [MAX_LEN-1:0] mask, top, pm, pm_prev, tr, d0, hp, hn, x;
        if (restart_text) restart_search();
        m       = active_len();
        mask    = len_mask(m);
        top     = 64'd1 << (m - 1);
        pm      = cfg_pm[sym] & mask;
        pm_prev = st_prev_valid ? (cfg_pm[st_prev_sym] & mask) : '0;
        // transposition of the previous and current symbol
        tr = ((~st_diag & pm) << 1) & pm_prev & mask;
        d0 = (tr | (((pm & st_vp) + st_vp) ^ st_vp) | pm | st_vn) & mask;
        hp = (st_vn | ~(d0 | st_vp)) & mask;
        hn = st_vp & d0 & mask;
        x  = (hp << 1) & mask;
        st_vp = ((hn << 1) | ~(d0 | x)) & mask;
        st_vn = x & d0 & mask;
        if ((hp & top) != 0 && int'(st_score) < m) st_score = st_score + 1'b1;
        if ((hn & top) != 0 && st_score != 0) st_score = st_score - 1'b1;
        if (int'(st_score) > m) st_score = DIST_W'(m);
        st_diag       = d0;
        st_prev_sym   = sym;
        st_prev_valid = 1'b1;
        return st_score;
    endfunction

    function automatic logic [SYM_W-1:0] rand_symbol();
        return SYM_W'($urandom_range(0, ALPHABET_DEF - 1));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IDX_LEN)
            cfg_len = val[LEN_W-1:0];
        else if (idx >= CFG_IDX_PM0 && idx < CFG_IDX_PM0 + 3'(ALPHABET_DEF))
            cfg_pm[idx - CFG_IDX_PM0] = val;
    endtask

    task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic restart);
        t_text_item item;
        item.sym     = sym;
        item.restart = restart;
        item.gap     = $urandom_range(0, tx_gap_max);
        symbol_q.push_back(item);
        symbols_issued++;
        phase_items++;
    endtask

    task automatic wait_drained();
        while (distances_seen != symbols_issued) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [LEN_W-1:0] len_val, input bit noisy);
        logic [CFG_DATA_W-1:0] masks[ALPHABET_DEF];
        int s, i;
        pattern_len_eff = (len_val == 0) ? 1 :
                          ((int'(len_val) > MAX_LEN) ? MAX_LEN : int'(len_val));
        for (i = 0; i < MAX_LEN; i++) pattern_sym[i] = rand_symbol();
        for (s = 0; s < ALPHABET_DEF; s++) masks[s] = noisy ? {$urandom, $urandom} : '0;
        if (!noisy)
            for (i = 0; i < MAX_LEN; i++) masks[pattern_sym[i]][i] = 1'b1;
        cfg_write(CFG_IDX_LEN, CFG_DATA_W'(len_val));
        for (s = 0; s < ALPHABET_DEF; s++) cfg_write(CFG_IDX_PM0 + 3'(s), masks[s]);
        i_cfg_valid <= 1'b0;
    endtask

    // one configuration write, possibly to a spare index, the running text carries on
    task automatic tweak_config();
        int pick;
        pick = $urandom_range(0, ALPHABET_DEF + 1);
        if (pick == 0)
            cfg_write(CFG_IDX_LEN, CFG_DATA_W'($urandom_range(0, 127)));
        else if (pick <= ALPHABET_DEF)
            cfg_write(CFG_IDX_PM0 + 3'(pick - 1), {$urandom, $urandom});
        else
            cfg_write(CFG_IDX_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    // random text with edited copies of the pattern mixed in
    task automatic gen_text(input bit keep_state);
        int stop, r, i;
        stop = phase_items + $urandom_range(4, 2 * pattern_len_eff + 8);
        push_symbol(rand_symbol(), !keep_state && ($urandom_range(0, 19) != 0));
        while (phase_items < stop) begin
            if ($urandom_range(0, 2) == 0) begin
                i = 0;
                while (i < pattern_len_eff) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        push_symbol(rand_symbol(), 1'b0);
                    end else if (r < 13 && i + 1 < pattern_len_eff) begin
                        push_symbol(pattern_sym[i + 1], 1'b0);
                        push_symbol(pattern_sym[i], 1'b0);
                        i++;
                    end else if (r < 16) begin
                        // drop this symbol
                    end else if (r < 19) begin
                        push_symbol(rand_symbol(), 1'b0);
                        push_symbol(pattern_sym[i], 1'b0);
                    end else begin
                        push_symbol(pattern_sym[i], 1'b0);
                    end
                    i++;
                end
            end else begin
                push_symbol(rand_symbol(), $urandom_range(0, 49) == 0);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        t_text_item head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                distance_q.push_back(predict_distance(i_text_symbol, i_new_text));
            if (!i_in_valid || !o_in_stall) begin
                if (symbol_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (symbol_q[0].gap > 0) begin
                    symbol_q[0].gap = symbol_q[0].gap - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    head = symbol_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_text_symbol <= head.sym;
                    i_new_text    <= head.restart;
                end
            end
        end
    end

    // monitor and result stall
    always @(posedge i_clk) begin : monitor
        logic [DIST_W-1:0] want;
        int stall_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (distance_q.size() == 0) begin
                    $error("distance: expected none, actual %0d", o_distance);
                    error_count++;
                end else begin
                    want = distance_q.pop_front();
                    distances_seen++;
                    if (o_distance !== want) begin
                        $error("distance: expected %0d, actual %0d", want, o_distance);
                        error_count++;
                    end
                end
                stall_left = $urandom_range(0, rx_busy_max);
            end
            if (hold_ack != hold_req) begin
                hold_ack++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int i, r, phase, rand_count, size;
        bit carry_on;
        logic [LEN_W-1:0] len_val;

        cfg_len = LEN_RESET;
        for (i = 0; i < ALPHABET_DEF; i++) cfg_pm[i] = '0;
        restart_search();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration, first symbol without a text restart
        push_symbol(2'd0, 1'b0);
        push_symbol(2'd3, 1'b1);
        wait_drained();

        // length zero, extreme masks, writes past the register list
        cfg_write(CFG_IDX_LEN, '0);
        cfg_write(CFG_IDX_PM0, '1);
        cfg_write(CFG_IDX_PM0 + 3'd1, '0);
        cfg_write(CFG_IDX_PM0 + 3'd2, 64'h5555_5555_5555_5555);
        cfg_write(CFG_IDX_PM0 + 3'd3, 64'hAAAA_AAAA_AAAA_AAAA);
        for (i = 0; i < 3; i++) cfg_write(CFG_IDX_SPARE + 3'(i), '1);
        i_cfg_valid <= 1'b0;
        push_symbol(2'd0, 1'b1);
        push_symbol(2'd1, 1'b0);
        push_symbol(2'd2, 1'b0);
        push_symbol(2'd3, 1'b0);
        wait_drained();

        // pattern 0123, junk above the length, transposed text
        cfg_write(CFG_IDX_LEN, CFG_DATA_W'(4));
        cfg_write(CFG_IDX_PM0, 64'hFFFF_0000_0000_0001);
        cfg_write(CFG_IDX_PM0 + 3'd1, 64'h0000_0000_0000_0002);
        cfg_write(CFG_IDX_PM0 + 3'd2, 64'h0000_0000_0000_0004);
        cfg_write(CFG_IDX_PM0 + 3'd3, 64'h8000_0000_0000_0008);
        i_cfg_valid <= 1'b0;
        push_symbol(2'd1, 1'b1);
        push_symbol(2'd0, 1'b0);
        push_symbol(2'd2, 1'b0);
        push_symbol(2'd3, 1'b0);
        push_symbol(2'd0, 1'b1);
        push_symbol(2'd1, 1'b0);
        push_symbol(2'd3, 1'b0);
        push_symbol(2'd2, 1'b0);
        wait_drained();

        // oversized length taken as full word, state kept across the change
        load_pattern(7'd127, 1'b1);
        for (i = 0; i < 4; i++) push_symbol(rand_symbol(), i == 3);
        wait_drained();

        load_pattern(7'd64, 1'b0);
        for (i = 0; i < 4; i++) push_symbol(pattern_sym[i], i == 0);
        wait_drained();

        rand_count = 0;
        phase = 0;
        while (rand_count < RANDOM_ITEMS) begin
            carry_on = (phase != 0) && ($urandom_range(0, 5) == 0);
            if (carry_on) begin
                tweak_config();
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    len_val = LEN_W'($urandom_range(1, 12));
                else if (r < 9)
                    len_val = LEN_W'($urandom_range(13, MAX_LEN));
                else
                    len_val = $urandom_range(0, 1) ? 7'd0 : LEN_W'($urandom_range(65, 127));
                load_pattern(len_val, $urandom_range(0, 9) == 0);
            end
            tx_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 6;
            rx_busy_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            size = (phase == 0 || phase == 5) ? 400 : $urandom_range(30, 150);
            phase_items = 0;
            gen_text(carry_on);
            while (phase_items < size) gen_text(1'b0);
            // receiver holds off while the sender keeps offering
            if (phase == 0 || phase == 5) hold_req++;
            rand_count += phase_items;
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && distance_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
